[src/dps_pkg.sv]
// Shared types and constants for the dispense pump sequencer.
// No dependencies; imported by dps_core and dispense_pump_sequencer_top.
package dps_pkg;

   localparam int unsigned TimerWidth  = 16;
   localparam int unsigned TargetWidth = 9;
   localparam int unsigned CodeWidth   = 8;

   localparam logic [TimerWidth-1:0]  TIMEOUT_RESET = 16'd60;
   localparam logic [TimerWidth-1:0]  TIMER_MAX     = 16'hFFFF;
   localparam logic [TargetWidth-1:0] SHORT_PULSES  = 9'd97;
   localparam logic [TargetWidth-1:0] LONG_PULSES   = 9'd231;

   localparam logic [CodeWidth-1:0] CODE_SHORT = 8'd1;
   localparam logic [CodeWidth-1:0] CODE_LONG  = 8'd2;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_HEAT_CHECK = 3'd1,
      PH_HEAT_WAIT  = 3'd2,
      PH_START      = 3'd3,
      PH_DISPENSE   = 3'd4,
      PH_SERVED     = 3'd5,
      PH_PAUSE      = 3'd6,
      PH_PAUSE_WAIT = 3'd7
   } phase_type;

   typedef struct packed {
      logic                   request;
      logic                   set_volume;
      logic [CodeWidth-1:0]   volume_code;
      logic                   heat_ok;
      logic [TimerWidth-1:0]  flow_count;
   } item_type;

   typedef struct packed {
      logic                   pump_on;
      phase_type              phase;
      logic                   served;
      logic [TargetWidth-1:0] target_pulses;
   } result_type;

   // Volume code to flow pulses; centilitre codes are code * 1925 / 100, truncated.
   function automatic logic [TargetWidth-1:0] code_to_pulses(input logic [CodeWidth-1:0] code);
      logic [TargetWidth-1:0] pulses;
      case (code)
         CODE_SHORT: pulses = SHORT_PULSES;
         CODE_LONG:  pulses = LONG_PULSES;
         8'd6:       pulses = 9'd115;
         8'd7:       pulses = 9'd134;
         8'd8:       pulses = 9'd154;
         8'd9:       pulses = 9'd173;
         8'd10:      pulses = 9'd192;
         8'd11:      pulses = 9'd211;
         8'd12:      pulses = 9'd231;
         8'd13:      pulses = 9'd250;
         8'd14:      pulses = 9'd269;
         8'd15:      pulses = 9'd288;
         8'd16:      pulses = 9'd308;
         8'd17:      pulses = 9'd327;
         8'd18:      pulses = 9'd346;
         8'd19:      pulses = 9'd365;
         8'd20:      pulses = 9'd385;
         default:    pulses = '0;
      endcase
      return pulses;
   endfunction

endpackage

[src/dps_core.sv]
// Sequencer state and one-tick step logic for the dispense pump sequencer.
// Depends on dps_pkg; instantiated by dispense_pump_sequencer_top.
module dps_core
   import dps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  item_type              item,
   input  logic [TimerWidth-1:0] timeout,
   output result_type            result
);

   phase_type               phase_ff, phase_in;
   logic                    pending_ff, pending_in;
   logic [TargetWidth-1:0]  target_ff, target_in;
   logic [TimerWidth-1:0]   timer_ff, timer_in;
   logic                    pump_ff, pump_in;
   logic                    served;
   logic [TargetWidth-1:0]  target_pre;
   logic [TimerWidth-1:0]   timer_inc;
   logic                    timer_expired;

   assign timer_inc     = (timer_ff == TIMER_MAX) ? TIMER_MAX : timer_ff + 1'b1;
   assign timer_expired = timer_ff > timeout;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pending_ff <= 1'b0;
         target_ff  <= '0;
         timer_ff   <= '0;
         pump_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         target_ff  <= target_in;
         timer_ff   <= timer_in;
         pump_ff    <= pump_in;
      end
   end

   always_comb begin
      // apply volume and request before stepping
      target_pre = item.set_volume ? code_to_pulses(item.volume_code) : target_ff;
      target_in  = target_pre;
      pending_in = pending_ff | item.request;
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      pump_in    = pump_ff;
      served     = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (pending_in) phase_in = PH_HEAT_CHECK;
         end
         PH_HEAT_CHECK: begin
            phase_in = item.heat_ok ? PH_START : PH_HEAT_WAIT;
         end
         PH_HEAT_WAIT: begin
            if (item.heat_ok) phase_in = PH_START;
         end
         PH_START: begin
            timer_in = '0;
            phase_in = PH_DISPENSE;
         end
         PH_DISPENSE: begin
            pump_in = 1'b1;
            if (item.flow_count > {{(TimerWidth-TargetWidth){1'b0}}, target_pre}) begin
               phase_in = PH_SERVED;
            end else if (timer_expired) begin
               phase_in = PH_PAUSE;
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_SERVED: begin
            pump_in    = 1'b0;
            target_in  = '0;
            pending_in = 1'b0;
            served     = 1'b1;
            phase_in   = PH_IDLE;
         end
         PH_PAUSE: begin
            pump_in  = 1'b0;
            timer_in = '0;
            phase_in = PH_PAUSE_WAIT;
         end
         PH_PAUSE_WAIT: begin
            if (timer_expired) begin
               timer_in = '0;
               phase_in = PH_DISPENSE;
            end else begin
               timer_in = timer_inc;
            end
         end
      endcase
      result.pump_on       = pump_in;
      result.phase         = phase_in;
      result.served        = served;
      result.target_pulses = target_in;
   end

   a_served_to_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && result.served |=> phase_ff == PH_IDLE && target_ff == '0 && !pending_ff)
      else $error("served step did not return to idle with target cleared");

   a_dispense_pump: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_DISPENSE |=> pump_ff)
      else $error("pump not driven after a dispense step");

   a_pause_entry: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_PAUSE |=> phase_ff == PH_PAUSE_WAIT && !pump_ff && timer_ff == '0)
      else $error("pause step did not stop pump and clear timer");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !reset && !step_en |=> $stable(phase_ff) && $stable(timer_ff) && $stable(target_ff))
      else $error("sequencer state moved without a step");

endmodule

[src/dispense_pump_sequencer_top.sv]
// Top level of the dispense pump sequencer: stream ports, input and result
// registers, timeout register. Depends on dps_pkg and dps_core.
//
//   channel  dir  handshake            payload
//   req_     in   tvalid/tready        tdata[26:0]: request, set_volume, volume_code,
//                                      heat_ok, flow_count
//   rsp_     out  tvalid/tready        tdata[13:0]: pump_on, phase, served, target_pulses
//   csr_     in   wr_en (no wait)      wr_data[15:0]: timeout_ticks
//
// One request a cycle sustained while rsp_tready is high; a taken request passes
// through the input register, then the step logic into the result register.
// The result register and input register form a two-deep buffer, so a request
// is taken into an empty input register while a finished result waits for rsp_tready.
// Reset (synchronous, active high) returns the sequencer to idle, timeout to 60.
module dispense_pump_sequencer_top
   import dps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [0] request, [1] set_volume, [9:2] volume_code,
                                    // [10] heat_ok, [26:11] flow_count, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] pump_on, [3:1] phase, [4] served,
                                    // [13:5] target_pulses, rest zero
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic                  in_valid_ff;
   item_type              in_item_ff;
   logic                  out_valid_ff;
   result_type            out_result_ff;
   logic [TimerWidth-1:0] timeout_ff;
   logic                  advance;
   logic                  step_en;
   item_type              req_item;
   result_type            step_result;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step_en    = in_valid_ff && advance;

   assign req_item.request     = req_tdata[0];
   assign req_item.set_volume  = req_tdata[1];
   assign req_item.volume_code = req_tdata[9:2];
   assign req_item.heat_ok     = req_tdata[10];
   assign req_item.flow_count  = req_tdata[26:11];

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // hold the captured request until it moves into the step logic
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_result_ff <= step_result;
      end
   end

   dps_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .timeout (timeout_ff),
      .result  (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_result_ff.target_pulses, out_result_ff.served,
                        out_result_ff.phase, out_result_ff.pump_on};

endmodule

[tb/tb_dispense_pump_sequencer_top.sv]
// Self-checking bench for dispense_pump_sequencer_top: drives tick requests, predicts
// each status word and checks it on the result stream. Depends on dps_pkg and the RTL.
`timescale 1ns / 100ps
module tb_dispense_pump_sequencer_top;
   import dps_pkg::*;

   localparam int unsigned PULSES_PER_LITRE = 1925;
   localparam int unsigned CL_DIVISOR       = 100;
   localparam logic [CodeWidth-1:0] CODE_CL_MIN = 8'd6;
   localparam logic [CodeWidth-1:0] CODE_CL_MAX = 8'd20;
   localparam int unsigned WATCHDOG_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned TICKS_PER_PHASE  = 45;
   localparam int unsigned MAX_REPORTS      = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [0] request, [1] set_volume, [9:2] volume_code,
                                   // [10] heat_ok, [26:11] flow_count, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [0] pump_on, [3:1] phase, [4] served,
                                   // [13:5] target_pulses, rest zero
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   item_type    tick_queue[$];
   result_type  awaited_status[$];
   item_type    drive_tick;
   logic        req_taken = 1'b0;
   int          ticks_in_flight = 0;
   int unsigned ticks_queued = 0;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;

   // Sequencer state as the bench sees it
   phase_type              seq_phase   = PH_IDLE;
   logic                   seq_pending = 1'b0;
   logic [TargetWidth-1:0] seq_target  = '0;
   logic [TimerWidth-1:0]  seq_timer   = '0;
   logic                   seq_pump    = 1'b0;
   logic [TimerWidth-1:0]  seq_timeout = TIMEOUT_RESET;

   dispense_pump_sequencer_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [TargetWidth-1:0] volume_pulses(logic [CodeWidth-1:0] code);
      int unsigned scaled;
      scaled = code * PULSES_PER_LITRE / CL_DIVISOR;
      if (code == CODE_SHORT) return SHORT_PULSES;
      if (code == CODE_LONG) return LONG_PULSES;
      if (code >= CODE_CL_MIN && code <= CODE_CL_MAX) return scaled[TargetWidth-1:0];
      return '0;
   endfunction

   // One tick: apply volume and request first, then one phase step
   function automatic result_type step_sequencer(item_type t);
      result_type r;
      logic       served_now;
      served_now = 1'b0;
      if (t.set_volume) seq_target = volume_pulses(t.volume_code);
      if (t.request) seq_pending = 1'b1;
      case (seq_phase)
         PH_IDLE: begin
            if (seq_pending) seq_phase = PH_HEAT_CHECK;
         end
         PH_HEAT_CHECK: begin
            seq_phase = t.heat_ok ? PH_START : PH_HEAT_WAIT;
         end
         PH_HEAT_WAIT: begin
            if (t.heat_ok) seq_phase = PH_START;
         end
         PH_START: begin
            seq_timer = '0;
            seq_phase = PH_DISPENSE;
         end
         PH_DISPENSE: begin
            seq_pump = 1'b1;
            if (t.flow_count > seq_target) begin
               seq_phase = PH_SERVED;
            end else if (seq_timer > seq_timeout) begin
               seq_phase = PH_PAUSE;
            end else if (seq_timer != TIMER_MAX) begin
               seq_timer = seq_timer + 1'b1;
            end
         end
         PH_SERVED: begin
            seq_pump    = 1'b0;
            seq_target  = '0;
            seq_pending = 1'b0;
            served_now  = 1'b1;
            seq_phase   = PH_IDLE;
         end
         PH_PAUSE: begin
            seq_pump  = 1'b0;
            seq_timer = '0;
            seq_phase = PH_PAUSE_WAIT;
         end
         default: begin
            if (seq_timer > seq_timeout) begin
               seq_timer = '0;
               seq_phase = PH_DISPENSE;
            end else if (seq_timer != TIMER_MAX) begin
               seq_timer = seq_timer + 1'b1;
            end
         end
      endcase
      r.pump_on       = seq_pump;
      r.phase         = seq_phase;
      r.served        = served_now;
      r.target_pulses = seq_target;
      return r;
   endfunction

   task automatic queue_tick(logic req, logic setv, logic [CodeWidth-1:0] code,
                             logic heat, logic [TimerWidth-1:0] flow);
      item_type t;
      t.request     = req;
      t.set_volume  = setv;
      t.volume_code = code;
      t.heat_ok     = heat;
      t.flow_count  = flow;
      tick_queue.push_back(t);
      ticks_in_flight++;
      ticks_queued++;
   endtask

   function automatic logic [CodeWidth-1:0] valid_code();
      logic [CodeWidth-1:0] code;
      // 1 and 2 stay as short and long, 3..17 shift up to the centilitre codes
      code = CodeWidth'($urandom_range(1, 17));
      if (code > CODE_LONG) code = code + 8'd3;
      return code;
   endfunction

   // A whole cup: volume, request, heater warm-up, flow ramp, served and back to idle
   task automatic queue_brew();
      logic [CodeWidth-1:0] code;
      logic                 req_now;
      int unsigned          warmup;
      int unsigned          flow;
      int unsigned          step_max;
      int unsigned          n;
      code    = ($urandom_range(9) < 7) ? valid_code() : CodeWidth'($urandom_range(255));
      req_now = 1'($urandom_range(1));
      queue_tick(req_now, 1'b1, code, 1'($urandom_range(1)), '0);
      if (!req_now) queue_tick(1'b1, $urandom_range(7) == 0, valid_code(), 1'b0, '0);
      warmup = $urandom_range(0, 4);
      repeat (warmup) queue_tick(1'b0, 1'b0, '0, 1'b0, '0);
      repeat ($urandom_range(2, 3)) queue_tick(1'b0, 1'b0, '0, 1'b1, '0);
      flow     = $urandom_range(0, 30);
      step_max = $urandom_range(1, 40);
      n        = 0;
      while (flow <= 400 && n < 45) begin
         queue_tick($urandom_range(19) == 0, $urandom_range(24) == 0, valid_code(),
                    1'($urandom_range(1)), TimerWidth'(flow));
         flow = flow + $urandom_range(0, step_max);
         n++;
      end
      queue_tick(1'b0, 1'b0, '0, 1'b1, TimerWidth'($urandom_range(400, 65535)));
      // the served tick, sometimes with a request or volume that it must drop
      queue_tick($urandom_range(3) == 0, $urandom_range(3) == 0, valid_code(),
                 1'($urandom_range(1)), TimerWidth'($urandom_range(65535)));
      queue_tick(1'b0, 1'b0, '0, 1'($urandom_range(1)), '0);
   endtask

   task automatic queue_noise();
      repeat ($urandom_range(1, 3)) begin
         queue_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                    CodeWidth'($urandom_range(255)),
                    1'($urandom_range(1)), TimerWidth'($urandom_range(65535)));
      end
   endtask

   task automatic wait_drained();
      wait (ticks_in_flight == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(logic [TimerWidth-1:0] value);
      @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      seq_timeout = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Driver: hold a request until taken, then offer the next or idle
   always @(negedge clock) begin
      if (req_taken || !req_tvalid) begin
         req_taken = 1'b0;
         if (tick_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            drive_tick = tick_queue.pop_front();
            req_tdata  <= {5'b0, drive_tick.flow_count, drive_tick.heat_ok,
                           drive_tick.volume_code, drive_tick.set_volume, drive_tick.request};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Monitor: predict on each request taken, check each status word delivered
   always @(posedge clock) begin : monitor
      result_type seen;
      result_type want;
      logic       moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_tvalid && req_tready) begin
            awaited_status.push_back(step_sequencer(drive_tick));
            req_taken = 1'b1;
            moved     = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved              = 1'b1;
            seen.pump_on       = rsp_tdata[0];
            seen.phase         = phase_type'(rsp_tdata[3:1]);
            seen.served        = rsp_tdata[4];
            seen.target_pulses = rsp_tdata[13:5];
            if (awaited_status.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t: status word 0x%04h with nothing awaited", $realtime, rsp_tdata);
               error_count++;
            end else begin
               want = awaited_status.pop_front();
               ticks_in_flight--;
               if (seen !== want || rsp_tdata[15:14] !== 2'b00) begin
                  if (error_count < MAX_REPORTS) begin
                     $display("%0t: expected pump %0d phase %0d served %0d target %0d",
                              $realtime, want.pump_on, want.phase, want.served,
                              want.target_pulses);
                     $display("%0t: got pump %0d phase %0d served %0d target %0d pad %0d",
                              $realtime, seen.pump_on, seen.phase, seen.served,
                              seen.target_pulses, rsp_tdata[15:14]);
                  end
                  error_count++;
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_dispense_pump_sequencer_top: done, errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [TimerWidth-1:0] timeout_plan [6];
      int unsigned           phase_index;
      timeout_plan = '{16'd1, 16'd5, 16'hFFFF, 16'd3, TIMEOUT_RESET, 16'd0};
      timeout_plan[5] = TimerWidth'($urandom_range(1, 12));
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_timeout(16'd2);
      queue_tick(1'b0, 1'b0, '0, 1'b0, '0);
      queue_tick(1'b0, 1'b1, CODE_SHORT, 1'b0, '0);
      queue_tick(1'b1, 1'b0, '0, 1'b0, '0);
      queue_tick(1'b0, 1'b0, '0, 1'b0, '0);
      queue_tick(1'b0, 1'b0, '0, 1'b0, '0);
      queue_tick(1'b0, 1'b0, '0, 1'b1, '0);
      queue_tick(1'b0, 1'b0, '0, 1'b1, '0);
      // new volume while dispensing counts on the same tick
      queue_tick(1'b0, 1'b1, CODE_CL_MAX, 1'b1, '0);
      // hold flow at the target: no serve, run into the pause
      repeat (8) queue_tick(1'b0, 1'b0, '0, 1'b1, 16'd385);
      queue_tick(1'b0, 1'b0, '0, 1'b1, 16'd386);
      // request and volume on the served tick are dropped
      queue_tick(1'b1, 1'b1, 8'hFF, 1'b1, '0);
      queue_tick(1'b0, 1'b0, '0, 1'b1, '0);
      queue_tick(1'b1, 1'b1, CODE_CL_MIN, 1'b1, '0);
      queue_tick(1'b0, 1'b0, '0, 1'b1, '0);
      queue_tick(1'b0, 1'b0, '0, 1'b1, '0);
      queue_tick(1'b0, 1'b1, 8'd21, 1'b1, 16'hFFFF);
      queue_tick(1'b0, 1'b1, CODE_LONG, 1'b0, '0);
      queue_tick(1'b0, 1'b1, 8'd5, 1'b0, 16'hFFFF);
      wait_drained();

      for (phase_index = 0; phase_index < 6; phase_index++) begin
         case (phase_index / 2)
            0: begin
               sender_idle_pct   = 38;
               receiver_idle_pct = 88;
            end
            1: begin
               sender_idle_pct   = 88;
               receiver_idle_pct = 38;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         write_timeout(timeout_plan[phase_index]);
         ticks_queued = 0;
         while (ticks_queued < TICKS_PER_PHASE) begin
            if ($urandom_range(99) < 85) queue_brew();
            else queue_noise();
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("tb_dispense_pump_sequencer_top: done, clean");
      end else begin
         $display("tb_dispense_pump_sequencer_top: done, errors");
      end
      $finish;
   end

endmodule
